[hw/rtl/skc_pkg.sv]
package skc_pkg;

  // Deck geometry and card codes.
  localparam int DECK_CARDS = 54;
  localparam int CARD_W     = 6;
  localparam int LETTER_W   = 5;
  localparam int ALPHA      = 26;

  typedef logic [CARD_W-1:0]   card_t;
  typedef logic [LETTER_W-1:0] letter_t;

  localparam card_t JOKER_A = card_t'(DECK_CARDS - 1);
  localparam card_t JOKER_B = card_t'(DECK_CARDS);

  // Request codes.
  typedef enum logic [1:0] {
    REQ_RESET   = 2'd0,
    REQ_KEY     = 2'd1,
    REQ_ENCRYPT = 2'd2,
    REQ_DECRYPT = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0] req_type;
    letter_t    letter_value;
  } in_item_t;

  typedef struct packed {
    letter_t out_letter;
    letter_t key_letter;
  } out_item_t;

  // Value of a card for counting: either joker counts as joker A.
  function automatic card_t card_val(input card_t card);
    card_val = (card > JOKER_A) ? JOKER_A : card;
  endfunction

endpackage

[hw/rtl/solitaire_keystream_cipher.sv]
// Solitaire keystream cipher, one letter per item.
// Input channel (in_valid, in_stall, in_item): req_type selects deck reset,
// keying with a passphrase letter, encryption or decryption of one letter.
// Result channel (out_valid, out_stall, out_item): exactly one item per
// request, carrying the output letter and the keystream letter (both zero
// for reset and keying).
// The deck sits in a ring of 54 registers. A single rotate/swap unit does
// all the mixing under a sequencer, one rotation step or swap per cycle.
// One keystream round is a full pass of the ring that locates the jokers,
// the joker steps (a swap, or a rotation plus a swap when a joker wraps
// from the bottom, at most two wraps a round), the triple cut, the count
// cut and a full turn to read the output card. Rounds repeat while the
// output card is a joker. Keying skips the read and adds the letter cut.
// A deck reset loads the ordered deck on acceptance and then goes
// straight to its result.
// in_stall is high from acceptance until the result has been loaded into
// the output register.
// Reset puts the deck back in order 1..54 and empties the output register.
// A stalled result stays in the output register; the next item may be
// accepted meanwhile, and its result waits until the register frees up.
module solitaire_keystream_cipher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  skc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output skc_pkg::out_item_t out_item
);
  import skc_pkg::*;

  typedef logic [CARD_W-1:0] pos_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_JMOVE, S_JSWAP, S_TC1, S_TC2, S_CC, S_KEYCUT,
    S_PEEK0, S_PEEK, S_CHECK, S_ROT, S_FIN
  } state_t;

  typedef enum logic [1:0] {OP_NONE, OP_LOAD, OP_ROT, OP_SWAP} op_t;

  localparam pos_t DECK_LEN = pos_t'(DECK_CARDS);
  localparam pos_t LAST_POS = pos_t'(DECK_CARDS - 1);
  localparam int   CHAIN_W  = LETTER_W + 2;

  state_t    state_r, state_nxt, ret_r, ret_nxt;
  card_t     deck_r [DECK_CARDS];
  card_t     deck_nxt [DECK_CARDS];
  req_t      req_r, req_nxt;
  letter_t   letter_r, letter_nxt;
  pos_t      cnt_r, cnt_nxt;
  pos_t      a_pos_r, a_pos_nxt, b_pos_r, b_pos_nxt;
  logic [1:0] jsel_r, jsel_nxt;
  pos_t      rot_len_r, rot_len_nxt, rot_cnt_r, rot_cnt_nxt;
  card_t     pv_r, pv_nxt, card_r, card_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  op_t       op;
  pos_t      op_len, op_pos;

  // Joker move, cut and result helpers.
  pos_t jpos, joth, jpos_new, joth_new;
  pos_t lo, hi;
  letter_t key_val;
  logic [CHAIN_W-1:0] sum_w;

  function automatic logic [CHAIN_W-1:0] mod_alpha(input logic [CHAIN_W-1:0] x);
    logic [CHAIN_W-1:0] y;
    y = x;
    for (int k = 0; k < 3; k++) begin
      if (y >= CHAIN_W'(ALPHA)) y = y - CHAIN_W'(ALPHA);
    end
    mod_alpha = y;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    req_nxt       = req_r;
    letter_nxt    = letter_r;
    cnt_nxt       = cnt_r;
    a_pos_nxt     = a_pos_r;
    b_pos_nxt     = b_pos_r;
    jsel_nxt      = jsel_r;
    rot_len_nxt   = rot_len_r;
    rot_cnt_nxt   = rot_cnt_r;
    pv_nxt        = pv_r;
    card_nxt      = card_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_item_nxt  = out_item_r;
    op            = OP_NONE;
    op_len        = DECK_LEN;
    op_pos        = '0;
    jpos          = (jsel_r == 2'd0) ? a_pos_r : b_pos_r;
    joth          = (jsel_r == 2'd0) ? b_pos_r : a_pos_r;
    jpos_new      = jpos;
    joth_new      = joth;
    lo            = (a_pos_r < b_pos_r) ? a_pos_r : b_pos_r;
    hi            = (a_pos_r < b_pos_r) ? b_pos_r : a_pos_r;
    key_val       = (card_r > card_t'(ALPHA)) ? letter_t'(card_r - card_t'(ALPHA))
                                              : letter_t'(card_r);
    sum_w         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = req_t'(in_item.req_type);
          letter_nxt = in_item.letter_value;
          cnt_nxt    = '0;
          if (req_t'(in_item.req_type) == REQ_RESET) begin
            op        = OP_LOAD;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end
      // Full turn of the ring, noting where each joker passes the top.
      S_FIND: begin
        op = OP_ROT;
        if (deck_r[0] == JOKER_A) a_pos_nxt = cnt_r;
        if (deck_r[0] == JOKER_B) b_pos_nxt = cnt_r;
        if (cnt_r == LAST_POS) begin
          jsel_nxt  = 2'd0;
          state_nxt = S_JMOVE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // One joker step: a swap, or from the bottom a turn plus a swap.
      S_JMOVE: begin
        if (jpos == LAST_POS) begin
          jpos_new    = pos_t'(1);
          joth_new    = (joth != '0) ? joth + 1'b1 : joth;
          rot_len_nxt = DECK_LEN;
          rot_cnt_nxt = LAST_POS;
          ret_nxt     = S_JSWAP;
          state_nxt   = S_ROT;
        end else begin
          op       = OP_SWAP;
          op_pos   = jpos;
          jpos_new = jpos + 1'b1;
          joth_new = (joth == jpos + 1'b1) ? jpos : joth;
          if (jsel_r == 2'd2) state_nxt = S_TC1;
          else                jsel_nxt  = jsel_r + 1'b1;
        end
        if (jsel_r == 2'd0) begin
          a_pos_nxt = jpos_new;
          b_pos_nxt = joth_new;
        end else begin
          b_pos_nxt = jpos_new;
          a_pos_nxt = joth_new;
        end
      end
      S_JSWAP: begin
        op     = OP_SWAP;
        op_pos = '0;
        if (jsel_r == 2'd2) begin
          state_nxt = S_TC1;
        end else begin
          jsel_nxt  = jsel_r + 1'b1;
          state_nxt = S_JMOVE;
        end
      end
      // Triple cut as two rotations: bring the upper joker to the top,
      // then move the joker block behind the lower part.
      S_TC1: begin
        rot_len_nxt = DECK_LEN;
        rot_cnt_nxt = lo;
        ret_nxt     = S_TC2;
        state_nxt   = S_ROT;
      end
      S_TC2: begin
        rot_len_nxt = DECK_LEN - lo;
        rot_cnt_nxt = hi - lo + 1'b1;
        ret_nxt     = S_CC;
        state_nxt   = S_ROT;
      end
      // Count cut by the bottom card: rotate all but the bottom card.
      S_CC: begin
        rot_len_nxt = LAST_POS;
        rot_cnt_nxt = (card_val(deck_r[DECK_CARDS-1]) < LAST_POS)
                      ? card_val(deck_r[DECK_CARDS-1]) : '0;
        ret_nxt     = (req_r == REQ_KEY) ? S_KEYCUT : S_PEEK0;
        state_nxt   = S_ROT;
      end
      S_KEYCUT: begin
        rot_len_nxt = LAST_POS;
        rot_cnt_nxt = pos_t'(letter_r);
        ret_nxt     = S_FIN;
        state_nxt   = S_ROT;
      end
      S_PEEK0: begin
        pv_nxt    = card_val(deck_r[0]);
        cnt_nxt   = '0;
        state_nxt = S_PEEK;
      end
      // Full turn, catching the card at the counted place.
      S_PEEK: begin
        op = OP_ROT;
        if (cnt_r == pv_r) card_nxt = deck_r[0];
        if (cnt_r == LAST_POS) state_nxt = S_CHECK;
        else                   cnt_nxt   = cnt_r + 1'b1;
      end
      S_CHECK: begin
        if (card_r >= JOKER_A) begin
          cnt_nxt   = '0;
          state_nxt = S_FIND;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_ROT: begin
        if (rot_cnt_r == '0) begin
          state_nxt = ret_r;
        end else begin
          op          = OP_ROT;
          op_len      = rot_len_r;
          rot_cnt_nxt = rot_cnt_r - 1'b1;
        end
      end
      S_FIN: begin
        if (req_r == REQ_ENCRYPT) begin
          sum_w = CHAIN_W'(letter_r) + CHAIN_W'(key_val);
        end else begin
          sum_w = CHAIN_W'(letter_r) + CHAIN_W'(2 * ALPHA) - CHAIN_W'(key_val);
        end
        sum_w = mod_alpha(sum_w);
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (req_r == REQ_ENCRYPT || req_r == REQ_DECRYPT) begin
            out_item_nxt.key_letter = key_val;
            out_item_nxt.out_letter = (sum_w == '0) ? letter_t'(ALPHA)
                                                    : letter_t'(sum_w);
          end else begin
            out_item_nxt.key_letter = '0;
            out_item_nxt.out_letter = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Shared load/rotate/swap unit on the deck ring.
  always_comb begin
    for (int i = 0; i < DECK_CARDS; i++) deck_nxt[i] = deck_r[i];
    unique case (op)
      OP_LOAD: begin
        for (int i = 0; i < DECK_CARDS; i++) deck_nxt[i] = card_t'(i + 1);
      end
      OP_ROT: begin
        for (int i = 0; i < DECK_CARDS - 1; i++) begin
          if (pos_t'(i) < op_len - 1'b1)       deck_nxt[i] = deck_r[i+1];
          else if (pos_t'(i) == op_len - 1'b1) deck_nxt[i] = deck_r[0];
        end
        if (op_len == DECK_LEN) deck_nxt[DECK_CARDS-1] = deck_r[0];
      end
      OP_SWAP: begin
        for (int i = 0; i < DECK_CARDS - 1; i++) begin
          if (pos_t'(i) == op_pos) deck_nxt[i] = deck_r[i+1];
        end
        for (int i = 1; i < DECK_CARDS; i++) begin
          if (pos_t'(i) == op_pos + 1'b1) deck_nxt[i] = deck_r[i-1];
        end
      end
      default: ;
    endcase
  end

  // State, deck and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DECK_CARDS; i++) deck_r[i] <= card_t'(i + 1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < DECK_CARDS; i++) deck_r[i] <= deck_nxt[i];
    end
    ret_r      <= ret_nxt;
    req_r      <= req_nxt;
    letter_r   <= letter_nxt;
    cnt_r      <= cnt_nxt;
    a_pos_r    <= a_pos_nxt;
    b_pos_r    <= b_pos_nxt;
    jsel_r     <= jsel_nxt;
    rot_len_r  <= rot_len_nxt;
    rot_cnt_r  <= rot_cnt_nxt;
    pv_r       <= pv_nxt;
    card_r     <= card_nxt;
    out_item_r <= out_item_nxt;
  end

  // The tracked joker places must match the deck during the joker moves.
  a_jokers_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_JMOVE |-> deck_r[a_pos_r] == JOKER_A && deck_r[b_pos_r] == JOKER_B)
    else $error("joker positions lost track of the deck");

  // A rotation never runs with a length outside the deck.
  a_rot_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROT && rot_cnt_r != '0 |-> rot_len_r != '0 && rot_len_r <= DECK_LEN)
    else $error("rotation length out of range");

  // Letters on the result channel are always in range.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_item_r.out_letter <= letter_t'(ALPHA)
                 && out_item_r.key_letter <= letter_t'(ALPHA))
    else $error("result letter out of range");

  // The keystream card behind an encrypt or decrypt result is an ordinary card, never zero or a joker.
  a_key_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && (req_r == REQ_ENCRYPT || req_r == REQ_DECRYPT)
    |-> card_r != '0 && card_r < JOKER_A)
    else $error("keystream card is not an ordinary card");

endmodule

[verif/tb_solitaire_keystream_cipher.sv]
`timescale 1ns / 100ps

module tb_solitaire_keystream_cipher;
  import skc_pkg::*;

  localparam int WATCHDOG_CYCLES = 40000;
  localparam int RANDOM_ITEMS    = 1200;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  solitaire_keystream_cipher DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predicted deck, top card at index 0.
  card_t     deck_model [DECK_CARDS];
  out_item_t letters_due [$];
  int        error_count;
  int        idle_cycles;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        items_sent;
  int        items_checked;
  int        req_count [4];

  function automatic int value_of(card_t card);
    return (card > JOKER_A) ? int'(JOKER_A) : int'(card);
  endfunction

  function automatic int locate(card_t card);
    for (int i = 0; i < DECK_CARDS; i++) begin
      if (deck_model[i] == card) return i;
    end
    return DECK_CARDS;
  endfunction

  function automatic void order_deck();
    for (int i = 0; i < DECK_CARDS; i++) deck_model[i] = card_t'(i + 1);
  endfunction

  // A joker steps down one place; from the bottom it lands below the top card.
  function automatic void move_joker(card_t card);
    int    pos;
    card_t swap_card;
    pos = locate(card);
    if (pos == DECK_CARDS - 1) begin
      for (int i = DECK_CARDS - 1; i >= 2; i--) deck_model[i] = deck_model[i-1];
      deck_model[1] = card;
    end else begin
      swap_card = deck_model[pos+1];
      deck_model[pos+1] = deck_model[pos];
      deck_model[pos] = swap_card;
    end
  endfunction

  function automatic void cut_around_jokers();
    card_t scratch [DECK_CARDS];
    int    pos_a;
    int    pos_b;
    int    lo;
    int    hi;
    int    n;
    pos_a = locate(JOKER_A);
    pos_b = locate(JOKER_B);
    lo = (pos_a < pos_b) ? pos_a : pos_b;
    hi = (pos_a < pos_b) ? pos_b : pos_a;
    n = 0;
    for (int i = hi + 1; i < DECK_CARDS; i++) begin
      scratch[n] = deck_model[i];
      n++;
    end
    for (int i = lo; i <= hi; i++) begin
      scratch[n] = deck_model[i];
      n++;
    end
    for (int i = 0; i < lo; i++) begin
      scratch[n] = deck_model[i];
      n++;
    end
    deck_model = scratch;
  endfunction

  // The top cnt cards go just above the bottom card.
  function automatic void cut_by_count(int cnt);
    card_t scratch [DECK_CARDS];
    int    rest;
    if (cnt == 0 || cnt >= DECK_CARDS - 1) return;
    rest = DECK_CARDS - 1 - cnt;
    for (int i = 0; i < rest; i++) scratch[i] = deck_model[cnt + i];
    for (int i = 0; i < cnt; i++) scratch[rest + i] = deck_model[i];
    scratch[DECK_CARDS-1] = deck_model[DECK_CARDS-1];
    deck_model = scratch;
  endfunction

  function automatic void shuffle_round();
    move_joker(JOKER_A);
    move_joker(JOKER_B);
    move_joker(JOKER_B);
    cut_around_jokers();
    cut_by_count(value_of(deck_model[DECK_CARDS-1]));
  endfunction

  function automatic int draw_key_letter();
    card_t card;
    forever begin
      shuffle_round();
      card = deck_model[value_of(deck_model[0]) % DECK_CARDS];
      if (card >= 1 && card < JOKER_A) return ((int'(card) - 1) % ALPHA) + 1;
    end
  endfunction

  // Advance the predicted deck for one request and return its result.
  function automatic out_item_t predict_letters(in_item_t item);
    out_item_t res;
    int        k;
    int        r;
    res = '0;
    case (req_t'(item.req_type))
      REQ_RESET: begin
        order_deck();
      end
      REQ_KEY: begin
        shuffle_round();
        cut_by_count(int'(item.letter_value));
      end
      default: begin
        k = draw_key_letter();
        if (req_t'(item.req_type) == REQ_ENCRYPT) begin
          r = (int'(item.letter_value) + k) % ALPHA;
        end else begin
          r = (int'(item.letter_value) + 2 * ALPHA - k) % ALPHA;
        end
        if (r == 0) r = ALPHA;
        res.out_letter = letter_t'(r);
        res.key_letter = letter_t'(k);
      end
    endcase
    return res;
  endfunction

  // Directed rows. A hand-typed result is used where has_result is set.
  typedef struct {
    req_t      req;
    int        letter;
    bit        has_result;
    out_item_t result;
  } directed_row_t;

  directed_row_t directed_rows [] = '{
    '{REQ_RESET,   0,  1'b1, '0},
    '{REQ_ENCRYPT, 1,  1'b0, '0},
    '{REQ_DECRYPT, 26, 1'b0, '0},
    '{REQ_ENCRYPT, 0,  1'b0, '0},
    '{REQ_ENCRYPT, 31, 1'b0, '0},
    '{REQ_DECRYPT, 0,  1'b0, '0},
    '{REQ_DECRYPT, 27, 1'b0, '0},
    '{REQ_RESET,   31, 1'b1, '0},
    '{REQ_KEY,     0,  1'b1, '0},
    '{REQ_KEY,     1,  1'b1, '0},
    '{REQ_KEY,     26, 1'b1, '0},
    '{REQ_KEY,     27, 1'b1, '0},
    '{REQ_KEY,     31, 1'b1, '0},
    '{REQ_ENCRYPT, 13, 1'b0, '0},
    '{REQ_DECRYPT, 13, 1'b0, '0},
    '{REQ_RESET,   21, 1'b1, '0},
    '{REQ_DECRYPT, 1,  1'b0, '0},
    '{REQ_ENCRYPT, 26, 1'b0, '0}
  };

  // Hold one item on the input until it is accepted. Valid stays high after
  // acceptance until the next item or an idle cycle replaces it.
  task automatic send_item(in_item_t item, bit use_typed, out_item_t typed);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_letters(item);
    letters_due.push_back(use_typed ? typed : predicted);
    req_count[item.req_type]++;
    items_sent++;
  endtask

  // Mostly letters to cipher, with keying items and occasional deck resets.
  function automatic in_item_t random_item();
    in_item_t item;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 3) item.req_type = REQ_RESET;
    else if (pick < 25) item.req_type = REQ_KEY;
    else if (pick < 62) item.req_type = REQ_ENCRYPT;
    else item.req_type = REQ_DECRYPT;
    if ($urandom_range(9) == 0) item.letter_value = letter_t'($urandom_range(31));
    else item.letter_value = letter_t'($urandom_range(26, 1));
    return item;
  endfunction

  // Drop valid and wait until every expected result has come.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (letters_due.size() != 0) @(posedge clk);
  endtask

  // Receiver stall, redrawn every cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (letters_due.size() == 0) begin
        $error("Unexpected result out_letter=%0d key_letter=%0d",
               out_item.out_letter, out_item.key_letter);
        error_count++;
      end else begin
        want = letters_due.pop_front();
        items_checked++;
        if (out_item.out_letter !== want.out_letter) begin
          $error("out_letter expected %0d actual %0d", want.out_letter,
                 out_item.out_letter);
          error_count++;
        end
        if (out_item.key_letter !== want.key_letter) begin
          $error("key_letter expected %0d actual %0d", want.key_letter,
                 out_item.key_letter);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("Watchdog expired with %0d results outstanding", letters_due.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_item_t item;
    items_sent    = 0;
    req_count     = '{0, 0, 0, 0};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    order_deck();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    send_idle_pct = 37;
    recv_idle_pct = 55;
    foreach (directed_rows[i]) begin
      item.req_type     = directed_rows[i].req;
      item.letter_value = letter_t'(directed_rows[i].letter);
      send_item(item, directed_rows[i].has_result, directed_rows[i].result);
    end

    // Sender waits for every outstanding result once.
    wait_drained();

    // Random items over three idling phases.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 55;
        recv_idle_pct = 37;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_item(random_item(), 1'b0, '0);
    end

    wait_drained();
    repeat (400) @(posedge clk);

    $display("Sent %0d items: %0d deck resets, %0d keyings, %0d encrypts, %0d decrypts.",
             items_sent, req_count[0], req_count[1], req_count[2], req_count[3]);
    $display("Checked %0d results under three sender/receiver idling mixes.",
             items_checked);
    if (error_count == 0 && letters_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/skc_pkg.sv
hw/rtl/solitaire_keystream_cipher.sv
verif/tb_solitaire_keystream_cipher.sv
